// ===== rtl/core/hmn_pkg.sv =====
// Shared types, widths and codes of the history min/max normalizer.
package hmn_pkg;

  localparam int HMN_DEPTH = 16;
  localparam int IDX_W     = $clog2(HMN_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HMN_DEPTH - 1);

  localparam int SAMPLE_W = 17;
  localparam int HEIGHT_W = 8;
  localparam int PAD_W    = 16;
  localparam int SLOT_W   = 6;
  localparam int LEVEL_W  = 8;
  localparam int DIFF_W   = 18;
  localparam int DEN_W    = 18;
  localparam int NUM_W    = DIFF_W + HEIGHT_W;
  localparam int QUO_W    = LEVEL_W;
  localparam int QCNT_W   = $clog2(QUO_W);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_SPAN_PAD = CFG_IDX_W'(1);

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(32);
  localparam logic [PAD_W-1:0]    PAD_RESET    = PAD_W'(250);

  localparam logic ACT_PUSH      = 1'b0;
  localparam logic ACT_NORMALIZE = 1'b1;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
  } in_data_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_index;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } out_data_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_SLOT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } hmn_state_t;

endpackage

// ===== rtl/core/history_minmax_normalizer.sv =====
// Top level: sample history, min/max scan sequencer and per-slot level output.
//
// A push request gives no result. A normalize request keeps
// in_stall high until all HMN_DEPTH levels are delivered, oldest slot first,
// the newest flagged by last. With a filled newest slot it first scans every
// slot for min and max, then prepares the divisor; each filled slot then goes
// through the multiplier and the shared bit-per-cycle divider, while an empty
// slot or a flat history gives its level directly; out_stall can hold each
// result. Configuration writes are always ready and belong to idle time.
module history_minmax_normalizer
  import hmn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_data_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_data_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  hmn_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SAMPLE_W-1:0] mn_r, mn_nxt;
  logic [SAMPLE_W-1:0] mx_r, mx_nxt;
  logic                zero_r, zero_nxt;
  logic                half_r, half_nxt;
  logic [PAD_W-1:0]    pad_eff_r, pad_eff_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_data_t           out_data_r, out_data_nxt;
  logic [HEIGHT_W-1:0] height_r;
  logic [PAD_W-1:0]    pad_r;

  logic                push;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] newest;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                in_fire;
  logic [SAMPLE_W-1:0] span;
  logic                small_span;
  logic [DIFF_W-1:0]   diff;
  logic [NUM_W-1:0]    prod;

  hmn_history u_history (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_sample (in_data.sample),
    .rd_idx      (idx_r),
    .rd_data     (rd_data),
    .newest      (newest)
  );

  hmn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign span       = mx_r - mn_r;
  assign small_span = (span <= SAMPLE_W'(pad_r));
  assign diff       = DIFF_W'(rd_data) - DIFF_W'(mn_r) + DIFF_W'(pad_eff_r);
  assign prod       = NUM_W'(diff) * NUM_W'(height_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    mn_nxt        = mn_r;
    mx_nxt        = mx_r;
    zero_nxt      = zero_r;
    half_nxt      = half_r;
    pad_eff_nxt   = pad_eff_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    push          = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = num_r;
    div_req.den   = den_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.action == ACT_PUSH) begin
            push = 1'b1;
          end else begin
            idx_nxt   = '0;
            mn_nxt    = newest;
            mx_nxt    = newest;
            zero_nxt  = (newest == '0);
            half_nxt  = 1'b0;
            state_nxt = (newest == '0) ? ST_SLOT : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // empty slots take no part in min and max
        if (rd_data != '0) begin
          if (rd_data < mn_r) mn_nxt = rd_data;
          if (rd_data > mx_r) mx_nxt = rd_data;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_PREP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_PREP: begin
        // widen a small span by the pad on both sides
        pad_eff_nxt = small_span ? pad_r : '0;
        den_nxt     = DEN_W'(span) + (DEN_W'(pad_eff_nxt) << 1) + DEN_W'(1);
        half_nxt    = (mn_r == mx_r);
        state_nxt   = ST_SLOT;
      end
      ST_SLOT: begin
        out_data_nxt.slot_index = SLOT_W'(idx_r);
        out_data_nxt.last       = (idx_r == LAST_IDX);
        if (zero_r || (rd_data == '0)) begin
          out_data_nxt.level = '0;
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_OUT;
        end else if (half_r) begin
          out_data_nxt.level = LEVEL_W'(height_r >> 1);
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_OUT;
        end else begin
          num_nxt   = prod;
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          // raise a zero level to one for a filled slot
          out_data_nxt.level = (div_rsp.quo == '0) ? LEVEL_W'(1) : div_rsp.quo;
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_SLOT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    mn_r       <= mn_nxt;
    mx_r       <= mx_nxt;
    zero_r     <= zero_nxt;
    half_r     <= half_nxt;
    pad_eff_r  <= pad_eff_nxt;
    den_r      <= den_nxt;
    num_r      <= num_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RESET;
      pad_r    <= PAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DISPLAY_HEIGHT) begin
        height_r <= cfg_wdata[HEIGHT_W-1:0];
      end else if (cfg_index == CFG_SMALL_SPAN_PAD) begin
        pad_r <= cfg_wdata[PAD_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/hmn_history.sv =====
// Shift store of the most recent samples with one indexed read port.
module hmn_history
  import hmn_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [SAMPLE_W-1:0] push_sample,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [SAMPLE_W-1:0] rd_data,
  output logic [SAMPLE_W-1:0] newest
);

  logic [SAMPLE_W-1:0] store_r [HMN_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HMN_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (push) begin
      // advance toward the oldest slot
      for (int i = 0; i < HMN_DEPTH - 1; i++) begin
        store_r[i] <= store_r[i + 1];
      end
      store_r[HMN_DEPTH - 1] <= push_sample;
    end
  end

  assign rd_data = store_r[rd_idx];
  assign newest  = store_r[HMN_DEPTH - 1];

endmodule

// ===== rtl/core/hmn_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits.
module hmn_div
  import hmn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [NUM_W-1:0]  shifted;

  assign shifted = NUM_W'(den_r) << cnt_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = QCNT_W'(QUO_W - 1);
      rem_nxt  = req.num;
      den_nxt  = req.den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (rem_r >= shifted) begin
        rem_nxt        = rem_r - shifted;
        quo_nxt[cnt_r] = 1'b1;
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/core/hmn_checker.sv =====
// Port-level checks of the normalizer, bound to the top level.
module hmn_checker
  import hmn_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_data_t              in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_data_t             out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_norm_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.action == ACT_NORMALIZE) |=> in_stall)
    else $error("input taken again right after a normalize request");

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result shown while input is open");

  a_more_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> in_stall)
    else $error("block idle before the newest slot was delivered");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.slot_index == SLOT_W'(HMN_DEPTH - 1))
    else $error("last flag on a slot other than the newest");

endmodule

bind history_minmax_normalizer hmn_checker u_hmn_checker (.*);

// ===== test/history_minmax_normalizer_tb.sv =====
// Self-checking testbench for the history min/max normalizer: directed and random push/normalize traffic.
module history_minmax_normalizer_tb
  import hmn_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_data_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_data_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the sample history and the two registers
  logic [SAMPLE_W-1:0] history [HMN_DEPTH];
  logic [HEIGHT_W-1:0] height_cfg;
  logic [PAD_W-1:0]    pad_cfg;

  in_data_t  pending_requests[$];
  out_data_t expected_levels[$];

  int   mismatches;
  int   in_gap_max;
  int   out_stall_max;
  int   gap_left;
  int   stall_left;
  logic in_taken;
  logic out_taken;
  logic cfg_taken;

  history_minmax_normalizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Update the history for a push, or queue the sixteen levels of a normalize.
  function automatic void apply_request(in_data_t req);
    logic [SAMPLE_W-1:0] mn;
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] v;
    longint              lo;
    longint              span;
    longint              lvl;
    out_data_t           res;
    if (req.action == ACT_PUSH) begin
      for (int k = 0; k < HMN_DEPTH - 1; k++) history[k] = history[k + 1];
      history[HMN_DEPTH-1] = req.sample;
      return;
    end
    mn = history[HMN_DEPTH-1];
    mx = mn;
    for (int k = 0; k < HMN_DEPTH; k++) begin
      v = history[k];
      if (v != '0) begin
        if (v < mn) mn = v;
        if (v > mx) mx = v;
      end
    end
    lo   = longint'(mn);
    span = longint'(mx) - longint'(mn);
    // widen a narrow span by the pad below min and above max
    if (span <= longint'(pad_cfg)) begin
      lo   = lo - longint'(pad_cfg);
      span = span + 2 * longint'(pad_cfg);
    end
    for (int k = 0; k < HMN_DEPTH; k++) begin
      v = history[k];
      if (history[HMN_DEPTH-1] == '0 || v == '0) begin
        lvl = 0;
      end else if (mn == mx) begin
        lvl = longint'(height_cfg) / 2;
      end else begin
        lvl = ((longint'(v) - lo) * longint'(height_cfg)) / (span + 1);
        if (lvl == 0) lvl = 1;
        if (lvl > 255) lvl = 255;
      end
      res.slot_index = SLOT_W'(k);
      res.level      = LEVEL_W'(lvl);
      res.last       = (k == HMN_DEPTH - 1);
      expected_levels.push_back(res);
    end
  endfunction

  task automatic check_level(out_data_t got);
    out_data_t exp_level;
    if (expected_levels.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected level: slot %0d level %0d last %0b",
                 got.slot_index, got.level, got.last);
      mismatches++;
    end else begin
      exp_level = expected_levels.pop_front();
      if (got.slot_index !== exp_level.slot_index || got.level !== exp_level.level ||
          got.last !== exp_level.last) begin
        if (mismatches < 10)
          $display("mismatch: exp slot %0d level %0d last %0b, got slot %0d level %0d last %0b",
                   exp_level.slot_index, exp_level.level, exp_level.last,
                   got.slot_index, got.level, got.last);
        mismatches++;
      end
    end
  endtask

  // Sample handshakes at the rising edge; check each delivered level.
  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n && out_valid && !out_stall) check_level(out_data);
  end

  // Request driver. Nothing is taken until a normalize's last level, so predict
  // on presentation: the payload holds until it is taken, and requests stay in order.
  always @(negedge clk) begin : drive_requests
    in_data_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled request
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_requests.size() > 0) begin
      req = pending_requests.pop_front();
      apply_request(req);
      in_data  <= req;
      in_valid <= 1'b1;
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, in_gap_max);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result-side back-pressure, redrawn after every delivered level.
  always @(negedge clk) begin
    if (out_taken)
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, out_stall_max);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_request(logic act, logic [SAMPLE_W-1:0] smp);
    in_data_t req;
    req.action = act;
    req.sample = smp;
    pending_requests.push_back(req);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_levels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_DISPLAY_HEIGHT) height_cfg = val[HEIGHT_W-1:0];
    else if (idx == CFG_SMALL_SPAN_PAD) pad_cfg = val;
  endtask

  task automatic set_levels(int height, int pad);
    write_reg(CFG_DISPLAY_HEIGHT, CFG_DATA_W'(height));
    write_reg(CFG_SMALL_SPAN_PAD, CFG_DATA_W'(pad));
  endtask

  // Mostly pushes clustered around a base value, with some wide values, zeros
  // and extremes; pause the sender halfway until every level has come back.
  task automatic run_random(int count, int gap_max, int stall_max);
    int base;
    int s;
    int pick;
    in_gap_max    = gap_max;
    out_stall_max = stall_max;
    base = $urandom_range(1, 131071);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      if ($urandom_range(0, 4) == 0) begin
        queue_request(ACT_NORMALIZE, SAMPLE_W'($urandom_range(0, 131071)));
      end else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: s = 0;
          1: s = 131071;
          2: s = 1;
          3, 4, 5: s = $urandom_range(0, 131071);
          default: begin
            s = base + int'($urandom_range(0, 600)) - 300;
            if (s < 1) s = 1;
            if (s > 131071) s = 131071;
          end
        endcase
        queue_request(ACT_PUSH, SAMPLE_W'(s));
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_taken      = 1'b0;
    out_taken     = 1'b0;
    cfg_taken     = 1'b0;
    gap_left      = 0;
    stall_left    = 0;
    mismatches    = 0;
    in_gap_max    = 16;
    out_stall_max = 16;
    height_cfg    = HEIGHT_RESET;
    pad_cfg       = PAD_RESET;
    for (int k = 0; k < HMN_DEPTH; k++) history[k] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty history, flat history, narrow span, empty newest slot,
    // wide span with a slot that rounds to zero.
    queue_request(ACT_NORMALIZE, SAMPLE_W'(131071));
    queue_request(ACT_PUSH, SAMPLE_W'(100000));
    queue_request(ACT_NORMALIZE, SAMPLE_W'(0));
    queue_request(ACT_PUSH, SAMPLE_W'(100100));
    queue_request(ACT_NORMALIZE, SAMPLE_W'(0));
    queue_request(ACT_PUSH, SAMPLE_W'(0));
    queue_request(ACT_NORMALIZE, SAMPLE_W'(0));
    queue_request(ACT_PUSH, SAMPLE_W'(131071));
    queue_request(ACT_PUSH, SAMPLE_W'(1));
    queue_request(ACT_PUSH, SAMPLE_W'(70000));
    queue_request(ACT_NORMALIZE, SAMPLE_W'(0));
    wait_drained();

    // Full-scale height, no pad: a wide span is not widened.
    set_levels(255, 0);
    queue_request(ACT_PUSH, SAMPLE_W'(5));
    queue_request(ACT_PUSH, SAMPLE_W'(6));
    queue_request(ACT_NORMALIZE, SAMPLE_W'(0));
    queue_request(ACT_PUSH, SAMPLE_W'(6));
    queue_request(ACT_NORMALIZE, SAMPLE_W'(0));
    wait_drained();
    run_random(30, 16, 16);

    // Zero height and largest pad: filled slots clamp up to one.
    set_levels(0, 65535);
    queue_request(ACT_NORMALIZE, SAMPLE_W'(0));
    queue_request(ACT_PUSH, SAMPLE_W'(131071));
    queue_request(ACT_NORMALIZE, SAMPLE_W'(0));
    wait_drained();
    run_random(20, 0, 0);

    set_levels($urandom_range(0, 255), $urandom_range(0, 65535));
    run_random(25, 16, 16);

    set_levels(255, 65535);
    run_random(20, 16, 0);

    set_levels(1, $urandom_range(0, 300));
    run_random(20, 0, 16);

    set_levels(32, 250);
    run_random(25, 16, 16);

    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("history_minmax_normalizer_tb OK");
    end else begin
      $display("history_minmax_normalizer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("history_minmax_normalizer_tb NOT OK");
    $finish;
  end

endmodule
